FILE: hdl/utad_pkg.sv
package utad_pkg;

   // Precision requests above this saturate.
   localparam int MAX_PRECISION = 60;
   // No conversion emits more characters than this, prefix included.
   localparam int RESULT_LIMIT  = 62;

   localparam int VALUE_W   = 32;
   localparam int OP_W      = 2;
   localparam int PREC_W    = 7;
   localparam int CHAR_W    = 8;
   localparam int NIBBLE_W  = 4;
   localparam int DIGIT_CNT = 10;
   localparam int DIGITS_W  = DIGIT_CNT * NIBBLE_W;
   localparam int COUNT_W   = $clog2(RESULT_LIMIT + 1);
   localparam int ND_W      = $clog2(DIGIT_CNT + 1);

   localparam logic [OP_W-1:0] OP_DEC       = 2'd0;
   localparam logic [OP_W-1:0] OP_HEX_UPPER = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic size;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic decimal;
      logic conv_done;
      logic out_free;
      logic emit_last;
   } dp_status_type;

endpackage

FILE: hdl/utad_datapath.sv
module utad_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [utad_pkg::VALUE_W-1:0]        req_value,
   input  logic [utad_pkg::OP_W-1:0]           req_op,
   input  logic signed [utad_pkg::PREC_W-1:0]  req_precision,
   input  logic                                req_alt_form,
   input  utad_pkg::dp_cmd_type                cmd,
   output utad_pkg::dp_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [utad_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                rsp_last,
   output logic                                rsp_empty_res
);
   import utad_pkg::*;

   localparam int DABBLE_BITS  = 4;
   localparam int DABBLE_STEPS = VALUE_W / DABBLE_BITS;
   localparam int STEP_W       = $clog2(DABBLE_STEPS);

   // Four shift-and-add-3 iterations of the binary to BCD conversion.
   function automatic logic [DIGITS_W+VALUE_W-1:0] dabble(
      input logic [DIGITS_W-1:0] bcd_i,
      input logic [VALUE_W-1:0]  src_i
   );
      logic [DIGITS_W-1:0] bcd;
      logic [VALUE_W-1:0]  src;
      bcd = bcd_i;
      src = src_i;
      for (int b = 0; b < DABBLE_BITS; b++) begin
         for (int d = 0; d < DIGIT_CNT; d++) begin
            if (bcd[d*NIBBLE_W +: NIBBLE_W] >= 4'd5) begin
               bcd[d*NIBBLE_W +: NIBBLE_W] = bcd[d*NIBBLE_W +: NIBBLE_W] + 4'd3;
            end
         end
         bcd = {bcd[DIGITS_W-2:0], src[VALUE_W-1]};
         src = {src[VALUE_W-2:0], 1'b0};
      end
      return {bcd, src};
   endfunction

   logic [VALUE_W-1:0]  src_ff, src_in;
   logic [DIGITS_W-1:0] digits_ff, digits_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                hex_ff, hex_in;
   logic                upper_ff, upper_in;
   logic                prefix_ff, prefix_in;
   logic                empty_ff, empty_in;
   logic [COUNT_W-1:0]  prec_ff, prec_in;
   logic [ND_W-1:0]     nd_ff, nd_in;
   logic [COUNT_W-1:0]  width_ff, width_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                empty_out_ff, empty_out_in;

   logic                has_prec;
   logic [COUNT_W-1:0]  prec_raw;
   logic [ND_W-1:0]     nd_w;
   logic [COUNT_W-1:0]  width_w;
   logic [COUNT_W-1:0]  rem_m1;
   logic [ND_W-1:0]     digit_idx;
   logic [NIBBLE_W-1:0] nib;
   logic [COUNT_W:0]    rem_ext;
   logic [COUNT_W:0]    width_ext;
   logic [CHAR_W-1:0]   next_char;

   assign has_prec = ~req_precision[PREC_W-1];
   assign prec_raw = COUNT_W'(req_precision[PREC_W-2:0]);

   // Significant digit count: at least one, even for zero.
   always_comb begin
      nd_w = ND_W'(1);
      for (int i = 1; i < DIGIT_CNT; i++) begin
         if (digits_ff[i*NIBBLE_W +: NIBBLE_W] != '0) begin
            nd_w = ND_W'(i + 1);
         end
      end
   end

   always_comb begin
      width_w = (COUNT_W'(nd_w) > prec_ff) ? COUNT_W'(nd_w) : prec_ff;
      if (prefix_ff && (width_w > COUNT_W'(RESULT_LIMIT - 2))) begin
         width_w = COUNT_W'(RESULT_LIMIT - 2);
      end
   end

   assign rem_m1    = rem_ff - COUNT_W'(1);
   assign digit_idx = rem_m1[ND_W-1:0];
   assign rem_ext   = {1'b0, rem_ff};
   assign width_ext = {1'b0, width_ff};

   always_comb begin
      nib = '0;
      for (int i = 0; i < DIGIT_CNT; i++) begin
         if (digit_idx == ND_W'(i)) begin
            nib = digits_ff[i*NIBBLE_W +: NIBBLE_W];
         end
      end
   end

   // The remaining count decides which part of the text the next character belongs to.
   always_comb begin
      priority if (empty_ff) begin
         next_char = CHAR_NUL;
      end else if (rem_ff > width_ff) begin
         if (rem_ext == width_ext + (COUNT_W+1)'(2)) begin
            next_char = CHAR_ZERO;
         end else begin
            next_char = upper_ff ? CHAR_UPPER_X : CHAR_LOWER_X;
         end
      end else if (rem_ff > COUNT_W'(nd_ff)) begin
         next_char = CHAR_ZERO;
      end else if (nib <= 4'd9) begin
         next_char = CHAR_ZERO + CHAR_W'(nib);
      end else begin
         next_char = (upper_ff ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(nib) - 8'd10;
      end
   end

   always_comb begin
      src_in       = src_ff;
      digits_in    = digits_ff;
      step_in      = step_ff;
      hex_in       = hex_ff;
      upper_in     = upper_ff;
      prefix_in    = prefix_ff;
      empty_in     = empty_ff;
      prec_in      = prec_ff;
      nd_in        = nd_ff;
      width_in     = width_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;
      empty_out_in = empty_out_ff;

      if (cmd.load) begin
         hex_in    = (req_op != OP_DEC);
         upper_in  = (req_op >= OP_HEX_UPPER);
         prefix_in = (req_op != OP_DEC) && req_alt_form && (req_value != '0);
         empty_in  = (req_value == '0) && has_prec && (prec_raw == '0);
         if (!has_prec) begin
            prec_in = '0;
         end else if (prec_raw > COUNT_W'(MAX_PRECISION)) begin
            prec_in = COUNT_W'(MAX_PRECISION);
         end else begin
            prec_in = prec_raw;
         end
         step_in = '0;
         src_in  = req_value;
         if (req_op == OP_DEC) begin
            digits_in = '0;
         end else begin
            digits_in = DIGITS_W'(req_value);
         end
      end

      if (cmd.step) begin
         {digits_in, src_in} = dabble(digits_ff, src_ff);
         step_in = step_ff + STEP_W'(1);
      end

      if (cmd.size) begin
         nd_in    = nd_w;
         width_in = width_w;
         if (empty_ff) begin
            rem_in = COUNT_W'(1);
         end else begin
            rem_in = width_w + (prefix_ff ? COUNT_W'(2) : COUNT_W'(0));
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         char_in      = next_char;
         last_in      = (rem_ff == COUNT_W'(1));
         empty_out_in = empty_ff;
         rem_in       = rem_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      digits_ff    <= digits_in;
      hex_ff       <= hex_in;
      upper_ff     <= upper_in;
      prefix_ff    <= prefix_in;
      empty_ff     <= empty_in;
      prec_ff      <= prec_in;
      nd_ff        <= nd_in;
      width_ff     <= width_in;
      rem_ff       <= rem_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      empty_out_ff <= empty_out_in;
   end

   assign status.decimal   = ~hex_ff;
   assign status.conv_done = (step_ff == STEP_W'(DABBLE_STEPS - 1));
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;
   assign status.emit_last = (rem_ff == COUNT_W'(1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_out_ff;

endmodule

FILE: hdl/utad_controller.sv
module utad_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  utad_pkg::dp_status_type status,
   output utad_pkg::dp_cmd_type    cmd
);
   import utad_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // Hex digits are already in place, so only decimal needs the conversion passes.
            if (!status.decimal || status.conv_done) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.step = status.decimal;
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/unsigned_to_ascii_digits_core.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_value, req_op, req_precision, req_alt_form
// rsp       out        rsp_valid/rsp_ready    rsp_character, rsp_last, rsp_empty_res
//
// One item is worked on at a time. Hex items skip the conversion; decimal items
// first pass through the binary to BCD unit, which converts four bits per cycle.
// After that one character leaves per cycle while rsp_ready is not held low.
// A new item is taken as soon as the final character sits in the output register.
// Reset clears the controller and the output valid; stalls on rsp hold the output.
module unsigned_to_ascii_digits_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [utad_pkg::VALUE_W-1:0]        req_value,
   input  logic [utad_pkg::OP_W-1:0]           req_op,
   input  logic signed [utad_pkg::PREC_W-1:0]  req_precision,
   input  logic                                req_alt_form,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [utad_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                rsp_last,
   output logic                                rsp_empty_res
);
   import utad_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   utad_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   utad_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_op        (req_op),
      .req_precision (req_precision),
      .req_alt_form  (req_alt_form),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

FILE: hdl/utad_checker.sv
module utad_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [utad_pkg::CHAR_W-1:0]         rsp_character,
   input logic                                rsp_last,
   input logic                                rsp_empty_res
);
   import utad_pkg::*;

   // A stalled item keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character)
         && $stable(rsp_last) && $stable(rsp_empty_res))
      else $error("rsp item changed while stalled");

   // An empty conversion is a single item on its own.
   a_empty_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_character == CHAR_NUL))
      else $error("empty item without last or with a character");

   // Only one conversion is in progress at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken straight after the first");

   // No new item is taken while characters of the current one are still due.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("new item taken before the final character");

endmodule

bind unsigned_to_ascii_digits_core utad_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last),
   .rsp_empty_res (rsp_empty_res)
);
